>>> rtl/lcf_pkg.sv
// Package for the link connection manager: phase type, action codes, register
// indexes, reset values and event constants. No dependencies.
package lcf_pkg;

    typedef enum logic [1:0] {
        PH_IDLE          = 2'd0,
        PH_CONNECTING    = 2'd1,
        PH_CONNECTED     = 2'd2,
        PH_DISCONNECTING = 2'd3
    } phase_t;

    typedef enum logic [3:0] {
        ACT_NONE         = 4'd0,
        ACT_CREATE       = 4'd1,
        ACT_DISCONNECT   = 4'd2,
        ACT_CANCEL       = 4'd3,
        ACT_READ_VERSION = 4'd4,
        ACT_SET_DATALEN  = 4'd5,
        ACT_CONNECTED    = 4'd6,
        ACT_FAILED       = 4'd7,
        ACT_DISCONNECTED = 4'd8
    } action_t;

    typedef enum logic [2:0] {
        OP_CONNECT       = 3'd0,
        OP_DISCONNECT    = 3'd1,
        OP_CONN_DONE     = 3'd2,
        OP_DISCONN_DONE  = 3'd3,
        OP_CMD_STATUS    = 3'd4,
        OP_TICK          = 3'd5,
        OP_ACTIVITY      = 3'd6
    } operation_t;

    localparam logic [2:0] REG_CMD_TIMEOUT = 3'd0;
    localparam logic [2:0] REG_CREATE      = 3'd1;
    localparam logic [2:0] REG_CANCEL      = 3'd2;
    localparam logic [2:0] REG_DISCONNECT  = 3'd3;
    localparam logic [2:0] REG_DATALEN     = 3'd4;

    localparam logic [15:0] CMD_TIMEOUT_RESET = 16'd5000;
    localparam logic [15:0] CREATE_RESET      = 16'd5121;
    localparam logic [15:0] CANCEL_RESET      = 16'd5122;
    localparam logic [15:0] DISCONNECT_RESET  = 16'd5123;
    localparam logic [15:0] DATALEN_RESET     = 16'd6148;
    localparam logic [19:0] SUPERVISION_RESET = 20'd5000;

    localparam logic [7:0] ST_AUTH_FAIL     = 8'h06;
    localparam logic [7:0] ST_CONN_LIMIT    = 8'h0B;
    localparam logic [7:0] ST_BAD_ADDR      = 8'h0F;
    localparam logic [7:0] ST_BAD_PARAMS    = 8'h1E;
    localparam logic [7:0] RSN_USER_TERM    = 8'h13;
    localparam logic [7:0] RSN_CONN_TIMEOUT = 8'hB0;
    localparam logic [7:0] RSN_SUP_TIMEOUT  = 8'h08;

    localparam int DEFAULT_ADDR_BITS   = 48;
    localparam int DEFAULT_RETRY_LIMIT = 2;

    typedef struct packed {
        logic [3:0]  action;
        logic [7:0]  code;
        logic [15:0] handle;
        logic [47:0] address;
    } item_t;

endpackage

>>> rtl/link_connection_fsm.sv
// Top level of the link connection manager: input register, single-pass
// decision logic, three-entry result buffer and APB register file.
// Depends on lcf_pkg.
// Flow: an accepted beat is registered in the input register and decided once the
// result buffer is free; its results are then registered in the buffer. Up to three
// result beats leave one per cycle while out_ready is high, holding back the next input.
// A new input beat is taken when the input register is empty, or when its beat
// is being decided and the result buffer is empty or passing on its last beat.
// Reset (rst_n, asynchronous) sets phase idle and registers to their defaults.
module link_connection_fsm #(
    parameter int ADDR_BITS   = lcf_pkg::DEFAULT_ADDR_BITS,
    parameter int RETRY_LIMIT = lcf_pkg::DEFAULT_RETRY_LIMIT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [2:0]           operation,
    input  logic [ADDR_BITS-1:0] peer_address,
    input  logic [15:0]          sup_timeout_units,
    input  logic                 send_accepted,
    input  logic [2:0]           event_length,
    input  logic [7:0]           event_byte0,
    input  logic [7:0]           event_byte1,
    input  logic [7:0]           event_byte2,
    input  logic [7:0]           event_byte3,
    input  logic [7:0]           event_byte4,
    input  logic [31:0]          now_ms,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [3:0]           action,
    output logic [7:0]           action_code,
    output logic [15:0]          action_handle,
    output logic [ADDR_BITS-1:0] action_address,
    output logic                 call_ok,
    output logic                 last
);

    // Register file.
    logic [15:0] cmd_timeout_reg, create_op_reg, cancel_op_reg, disc_op_reg, datalen_op_reg;
    logic [2:0]  reg_idx;
    logic        cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_timeout_reg <= lcf_pkg::CMD_TIMEOUT_RESET;
            create_op_reg   <= lcf_pkg::CREATE_RESET;
            cancel_op_reg   <= lcf_pkg::CANCEL_RESET;
            disc_op_reg     <= lcf_pkg::DISCONNECT_RESET;
            datalen_op_reg  <= lcf_pkg::DATALEN_RESET;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                lcf_pkg::REG_CMD_TIMEOUT: cmd_timeout_reg <= pwdata[15:0];
                lcf_pkg::REG_CREATE:      create_op_reg   <= pwdata[15:0];
                lcf_pkg::REG_CANCEL:      cancel_op_reg   <= pwdata[15:0];
                lcf_pkg::REG_DISCONNECT:  disc_op_reg     <= pwdata[15:0];
                lcf_pkg::REG_DATALEN:     datalen_op_reg  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            lcf_pkg::REG_CMD_TIMEOUT: prdata = {16'd0, cmd_timeout_reg};
            lcf_pkg::REG_CREATE:      prdata = {16'd0, create_op_reg};
            lcf_pkg::REG_CANCEL:      prdata = {16'd0, cancel_op_reg};
            lcf_pkg::REG_DISCONNECT:  prdata = {16'd0, disc_op_reg};
            lcf_pkg::REG_DATALEN:     prdata = {16'd0, datalen_op_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    // Input register.
    logic                 iv_reg;
    logic [2:0]           op_reg;
    logic [ADDR_BITS-1:0] peer_reg;
    logic [15:0]          units_reg;
    logic                 acc_reg;
    logic [2:0]           len_reg;
    logic [7:0]           b_reg [5];
    logic [31:0]          now_reg;
    logic                 take_in, stage_go, buf_free;

    // Result buffer: up to three items, shifted out one per beat.
    lcf_pkg::item_t item_reg [3];
    logic [1:0]     cnt_reg, cnt_next;
    logic           ok_reg;

    assign buf_free = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && out_ready);
    assign stage_go = iv_reg && buf_free;
    assign in_ready = !iv_reg || stage_go;
    assign take_in  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            iv_reg <= 1'b0;
        else if (in_ready)
            iv_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            op_reg    <= operation;
            peer_reg  <= peer_address;
            units_reg <= sup_timeout_units;
            acc_reg   <= send_accepted;
            len_reg   <= (event_length > 3'd5) ? 3'd5 : event_length;
            b_reg[0]  <= event_byte0;
            b_reg[1]  <= event_byte1;
            b_reg[2]  <= event_byte2;
            b_reg[3]  <= event_byte3;
            b_reg[4]  <= event_byte4;
            now_reg   <= now_ms;
        end
    end

    // State.
    lcf_pkg::phase_t      phase_reg, phase_next;
    logic [ADDR_BITS-1:0] target_reg, target_next;
    logic [15:0]          handle_reg, handle_next;
    logic [19:0]          sup_reg, sup_next;
    logic [31:0]          win_reg, win_next, act_reg, act_next;
    logic [1:0]           retry_reg, retry_next;

    // Opcode echo search over offsets 0..2.
    function automatic logic [8:0] find_echo(input logic [7:0] b0, input logic [7:0] b1,
                                             input logic [7:0] b2, input logic [7:0] b3,
                                             input logic [7:0] b4, input logic [2:0] len,
                                             input logic [15:0] want);
        logic [8:0] r;
        r = 9'd0;
        if ({b1, b0} == want)
            r = {1'b1, b2};
        else if (len >= 3'd4 && {b2, b1} == want)
            r = {1'b1, b3};
        else if (len >= 3'd5 && {b3, b2} == want)
            r = {1'b1, b4};
        return r;
    endfunction

    logic [8:0]     e_cre, e_can, e_dis, e_dl;
    logic [15:0]    ev_handle, units_x10;
    logic [31:0]    win_eff, act_eff;
    lcf_pkg::item_t it [3];
    logic [1:0]     n;
    logic           ok;

    assign e_cre = find_echo(b_reg[0], b_reg[1], b_reg[2], b_reg[3], b_reg[4], len_reg,
                             create_op_reg);
    assign e_can = find_echo(b_reg[0], b_reg[1], b_reg[2], b_reg[3], b_reg[4], len_reg,
                             cancel_op_reg);
    assign e_dis = find_echo(b_reg[0], b_reg[1], b_reg[2], b_reg[3], b_reg[4], len_reg,
                             disc_op_reg);
    assign e_dl  = find_echo(b_reg[0], b_reg[1], b_reg[2], b_reg[3], b_reg[4], len_reg,
                             datalen_op_reg);
    assign ev_handle = {b_reg[2], b_reg[1]};
    assign units_x10 = units_reg;
    assign win_eff   = (win_reg == 32'd0) ? now_reg : win_reg;
    assign act_eff   = (act_reg == 32'd0) ? now_reg : act_reg;

    function automatic lcf_pkg::item_t mk(input lcf_pkg::action_t a, input logic [7:0] c,
                                          input logic [15:0] h, input logic [47:0] ad);
        lcf_pkg::item_t r;
        r.action  = a;
        r.code    = c;
        r.handle  = h;
        r.address = ad;
        return r;
    endfunction

    logic [47:0] peer48, target48;
    assign peer48   = 48'(peer_reg);
    assign target48 = 48'(target_reg);

    always_comb
    begin
        phase_next  = phase_reg;
        target_next = target_reg;
        handle_next = handle_reg;
        sup_next    = sup_reg;
        win_next    = win_reg;
        act_next    = act_reg;
        retry_next  = retry_reg;
        ok          = 1'b1;
        n           = 2'd0;
        it[0]       = mk(lcf_pkg::ACT_NONE, 8'd0, 16'd0, 48'd0);
        it[1]       = it[0];
        it[2]       = it[0];
        case (op_reg)
            lcf_pkg::OP_CONNECT:
            begin
                if (phase_reg != lcf_pkg::PH_IDLE)
                    ok = 1'b0;
                else
                begin
                    it[0] = mk(lcf_pkg::ACT_CREATE, 8'd0, 16'd0, peer48);
                    n     = 2'd1;
                    if (acc_reg)
                    begin
                        target_next = peer_reg;
                        sup_next    = 20'(units_x10) * 20'd10;
                        retry_next  = 2'd0;
                        phase_next  = lcf_pkg::PH_CONNECTING;
                        win_next    = 32'd0;
                    end
                    else
                        ok = 1'b0;
                end
            end
            lcf_pkg::OP_DISCONNECT:
            begin
                if (phase_reg == lcf_pkg::PH_CONNECTED || phase_reg == lcf_pkg::PH_CONNECTING)
                begin
                    if (phase_reg == lcf_pkg::PH_CONNECTED)
                        it[0] = mk(lcf_pkg::ACT_DISCONNECT, lcf_pkg::RSN_USER_TERM,
                                   handle_reg, 48'd0);
                    else
                        it[0] = mk(lcf_pkg::ACT_CANCEL, 8'd0, 16'd0, target48);
                    n = 2'd1;
                    if (acc_reg)
                    begin
                        phase_next = lcf_pkg::PH_DISCONNECTING;
                        win_next   = 32'd0;
                    end
                    else
                        ok = 1'b0;
                end
                else
                    ok = 1'b0;
            end
            lcf_pkg::OP_CONN_DONE:
            begin
                if (len_reg >= 3'd3)
                begin
                    if (b_reg[0] == lcf_pkg::ST_AUTH_FAIL || b_reg[0] == lcf_pkg::ST_CONN_LIMIT ||
                        b_reg[0] == lcf_pkg::ST_BAD_ADDR || b_reg[0] == lcf_pkg::ST_BAD_PARAMS)
                    begin
                        phase_next = lcf_pkg::PH_IDLE;
                        win_next   = 32'd0;
                        it[0]      = mk(lcf_pkg::ACT_FAILED, b_reg[0], 16'd0, 48'd0);
                        n          = 2'd1;
                    end
                    else if (phase_reg == lcf_pkg::PH_CONNECTING)
                    begin
                        handle_next = ev_handle;
                        phase_next  = lcf_pkg::PH_CONNECTED;
                        win_next    = 32'd0;
                        act_next    = 32'd0;
                        retry_next  = 2'd0;
                        it[0] = mk(lcf_pkg::ACT_READ_VERSION, 8'd0, ev_handle, 48'd0);
                        it[1] = mk(lcf_pkg::ACT_SET_DATALEN, 8'd0, ev_handle, 48'd0);
                        it[2] = mk(lcf_pkg::ACT_CONNECTED, 8'd0, ev_handle, 48'd0);
                        n     = 2'd3;
                    end
                end
            end
            lcf_pkg::OP_DISCONN_DONE:
            begin
                if (phase_reg != lcf_pkg::PH_IDLE &&
                    !(phase_reg == lcf_pkg::PH_CONNECTED && len_reg >= 3'd3 &&
                      ev_handle != 16'd0 && ev_handle != handle_reg))
                begin
                    phase_next = lcf_pkg::PH_IDLE;
                    win_next   = 32'd0;
                    it[0] = mk(lcf_pkg::ACT_DISCONNECTED,
                               (len_reg != 3'd0) ? b_reg[0] : 8'd0, handle_reg, 48'd0);
                    n     = 2'd1;
                end
            end
            lcf_pkg::OP_CMD_STATUS:
            begin
                if (len_reg >= 3'd3)
                begin
                    if (e_cre[8] && e_cre[7:0] != 8'd0)
                    begin
                        if (phase_reg == lcf_pkg::PH_CONNECTING)
                        begin
                            phase_next = lcf_pkg::PH_IDLE;
                            win_next   = 32'd0;
                            it[0]      = mk(lcf_pkg::ACT_FAILED, e_cre[7:0], 16'd0, 48'd0);
                            n          = 2'd1;
                        end
                    end
                    else if (e_can[8] && e_can[7:0] == 8'd0)
                    begin
                        if (phase_reg == lcf_pkg::PH_DISCONNECTING)
                        begin
                            phase_next = lcf_pkg::PH_IDLE;
                            win_next   = 32'd0;
                            it[0] = mk(lcf_pkg::ACT_DISCONNECTED, lcf_pkg::RSN_USER_TERM,
                                       handle_reg, 48'd0);
                            n     = 2'd1;
                        end
                    end
                    else if (e_dis[8] && e_dis[7:0] != 8'd0)
                    begin
                        if (phase_reg == lcf_pkg::PH_DISCONNECTING)
                            phase_next = lcf_pkg::PH_CONNECTED;
                    end
                    else if (e_dl[8] && e_dl[7:0] == lcf_pkg::ST_AUTH_FAIL &&
                             phase_reg == lcf_pkg::PH_CONNECTED &&
                             32'(retry_reg) < 32'(RETRY_LIMIT))
                    begin
                        retry_next = retry_reg + 2'd1;
                        it[0] = mk(lcf_pkg::ACT_SET_DATALEN, 8'd0, handle_reg, 48'd0);
                        n     = 2'd1;
                    end
                end
            end
            lcf_pkg::OP_TICK:
            begin
                win_next = win_eff;
                case (phase_reg)
                    lcf_pkg::PH_CONNECTING:
                    begin
                        if (now_reg - win_eff > 32'(cmd_timeout_reg))
                        begin
                            it[0] = mk(lcf_pkg::ACT_CANCEL, 8'd0, 16'd0, target48);
                            it[1] = mk(lcf_pkg::ACT_FAILED, lcf_pkg::RSN_CONN_TIMEOUT,
                                       16'd0, 48'd0);
                            n          = 2'd2;
                            phase_next = lcf_pkg::PH_IDLE;
                            win_next   = 32'd0;
                        end
                    end
                    lcf_pkg::PH_DISCONNECTING:
                    begin
                        if (now_reg - win_eff > 32'(cmd_timeout_reg))
                        begin
                            it[0] = mk(lcf_pkg::ACT_DISCONNECTED, lcf_pkg::RSN_SUP_TIMEOUT,
                                       handle_reg, 48'd0);
                            n          = 2'd1;
                            phase_next = lcf_pkg::PH_IDLE;
                            win_next   = 32'd0;
                        end
                    end
                    lcf_pkg::PH_CONNECTED:
                    begin
                        act_next = act_eff;
                        if (now_reg - act_eff > 32'(sup_reg))
                        begin
                            it[0] = mk(lcf_pkg::ACT_DISCONNECTED, lcf_pkg::RSN_SUP_TIMEOUT,
                                       handle_reg, 48'd0);
                            n          = 2'd1;
                            phase_next = lcf_pkg::PH_IDLE;
                            win_next   = 32'd0;
                            act_next   = 32'd0;
                        end
                    end
                    default: ;
                endcase
            end
            lcf_pkg::OP_ACTIVITY:
            begin
                if (phase_reg == lcf_pkg::PH_CONNECTED)
                    act_next = now_reg;
            end
            default: ;
        endcase
        if (n == 2'd0)
            n = 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= lcf_pkg::PH_IDLE;
            target_reg <= '0;
            handle_reg <= 16'd0;
            sup_reg    <= lcf_pkg::SUPERVISION_RESET;
            win_reg    <= 32'd0;
            act_reg    <= 32'd0;
            retry_reg  <= 2'd0;
        end
        else if (stage_go)
        begin
            phase_reg  <= phase_next;
            target_reg <= target_next;
            handle_reg <= handle_next;
            sup_reg    <= sup_next;
            win_reg    <= win_next;
            act_reg    <= act_next;
            retry_reg  <= retry_next;
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (stage_go)
            cnt_next = n;
        else if (cnt_reg != 2'd0 && out_ready)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (stage_go)
        begin
            item_reg[0] <= it[0];
            item_reg[1] <= it[1];
            item_reg[2] <= it[2];
            ok_reg      <= ok;
        end
        else if (cnt_reg != 2'd0 && out_ready)
        begin
            item_reg[0] <= item_reg[1];
            item_reg[1] <= item_reg[2];
        end
    end

    assign out_valid      = (cnt_reg != 2'd0);
    assign action         = item_reg[0].action;
    assign action_code    = item_reg[0].code;
    assign action_handle  = item_reg[0].handle;
    assign action_address = ADDR_BITS'(item_reg[0].address);
    assign call_ok        = ok_reg;
    assign last           = (cnt_reg == 2'd1);

    // Checks.
    a_no_load_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        stage_go |-> (cnt_reg == 2'd0 || (cnt_reg == 2'd1 && out_ready)))
        else $error("result buffer overwritten");

    a_retry_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(retry_reg) <= 32'(RETRY_LIMIT))
        else $error("retry count beyond limit");

    a_idle_unanchored: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_go && phase_next == lcf_pkg::PH_IDLE && phase_reg != lcf_pkg::PH_IDLE)
        |=> win_reg == 32'd0)
        else $error("window left anchored on entry to idle");

endmodule
